// File: hw/rtl/resource_barrier_tracker_unit_macros.svh
// Assertion macros shared by the resource barrier tracker RTL.
`ifndef RESOURCE_BARRIER_TRACKER_UNIT_MACROS_SVH
`define RESOURCE_BARRIER_TRACKER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define RBT_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("rbt assertion failed");

// Condition must never be seen at a clock edge outside reset.
`define RBT_ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("rbt forbidden condition seen");

`else

`define RBT_ASSERT(lbl, clk, rstn, prop)
`define RBT_ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

// File: hw/rtl/rbt_pkg.sv
// Types and constants shared by the resource barrier tracker modules.
package rbt_pkg;

    // Action codes of an input item.
    typedef logic [1:0] action_t;
    localparam action_t ACT_RECORD  = 2'd0;
    localparam action_t ACT_FLUSH   = 2'd1;
    localparam action_t ACT_RESTORE = 2'd2;

    // Barrier kinds of a result.
    typedef logic [1:0] kind_t;
    localparam kind_t KIND_NONE  = 2'd0;
    localparam kind_t KIND_UAV   = 2'd1;
    localparam kind_t KIND_TRANS = 2'd2;

    // Result status codes.
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // Reset value of the unordered-access state mask register.
    localparam logic [31:0] UAV_MASK_RESET = 32'd8;

    // One table entry as stored in the entry RAM.
    typedef struct packed {
        logic [31:0] key;
        logic [31:0] initial_mask;
        logic [31:0] last_mask;
        logic [31:0] current_mask;
        logic        uav_pending;
    } entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;
        logic    rd_en;
        logic    eval;
        logic    idx_inc;
        logic    insert;
        logic    finish;
        action_t op;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic count_zero;
        logic idx_last;
        logic key_hit;
    } dp_stat_t;

endpackage

// File: hw/rtl/rbt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: hw/rtl/rbt_ctrl.sv
// Controller state machine of the resource barrier tracker.
module rbt_ctrl
    import rbt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  action_t    action,
    input  dp_stat_t   stat,
    output ctrl_cmd_t  cmd,
    output logic       busy
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_READ   = 5'b00010,
        S_EVAL   = 5'b00100,
        S_INSERT = 5'b01000,
        S_DONE   = 5'b10000
    } state_t;

    state_t  state_reg, state_next;
    action_t op_reg, op_next;

    // Next state and command decode.
    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        cmd         = '0;
        cmd.op      = op_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    op_next  = action;
                    if (action == ACT_RECORD)
                    begin
                        state_next = stat.count_zero ? S_INSERT : S_READ;
                    end
                    else if (action == ACT_FLUSH || action == ACT_RESTORE)
                    begin
                        state_next = stat.count_zero ? S_DONE : S_READ;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                cmd.eval = 1'b1;
                if (op_reg == ACT_RECORD && stat.key_hit)
                begin
                    state_next = S_DONE;
                end
                else if (stat.idx_last)
                begin
                    state_next = (op_reg == ACT_RECORD) ? S_INSERT : S_DONE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_READ;
                end
            end
            S_INSERT:
            begin
                cmd.insert = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= ACT_RECORD;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// File: hw/rtl/rbt_datapath.sv
// Datapath of the resource barrier tracker: entry RAM, item registers and results.
module rbt_datapath
    import rbt_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_data,
    input  ctrl_cmd_t   cmd,
    output dp_stat_t    stat,
    input  logic [31:0] resource_key,
    input  logic [31:0] new_state,
    input  logic [31:0] initial_state,
    output logic        result_valid,
    output logic [1:0]  barrier_kind,
    output logic [31:0] barrier_resource,
    output logic [31:0] state_before,
    output logic [31:0] state_after,
    output logic        status,
    output logic        last_result
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_ENTRIES);

    // Control registers.
    logic [31:0]      uav_mask_reg;
    logic [CNT_W-1:0] count_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             status_reg;
    logic             pend_valid_reg;
    logic             result_valid_reg;

    // Payload registers.
    logic [31:0] key_reg, state_reg, init_reg;
    kind_t       pend_kind_reg;
    logic [31:0] pend_key_reg, pend_before_reg, pend_after_reg;
    kind_t       out_kind_reg;
    logic [31:0] out_key_reg, out_before_reg, out_after_reg;
    logic        out_status_reg, out_last_reg;

    // Entry RAM ports.
    entry_t           rd_entry;
    entry_t           wr_entry;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;

    // Result of evaluating the entry just read.
    logic        res_new;
    kind_t       res_kind;
    logic [31:0] res_before, res_after;
    logic        key_hit;
    logic        table_full;

    rbt_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (TABLE_ENTRIES)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (cmd.rd_en),
        .rd_addr (idx_reg),
        .rd_data (rd_entry)
    );

    assign key_hit    = (rd_entry.key == key_reg);
    assign table_full = (count_reg == FULL_COUNT);

    // Status toward the controller.
    assign stat.count_zero = (count_reg == '0);
    assign stat.idx_last   = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
    assign stat.key_hit    = key_hit;

    // Per-entry evaluation and table updates.
    always_comb
    begin
        wr_en      = 1'b0;
        wr_addr    = idx_reg;
        wr_entry   = rd_entry;
        res_new    = 1'b0;
        res_kind   = KIND_NONE;
        res_before = '0;
        res_after  = '0;
        if (cmd.eval)
        begin
            case (cmd.op)
                ACT_RECORD:
                begin
                    if (key_hit)
                    begin
                        wr_en                 = 1'b1;
                        wr_entry.current_mask = state_reg;
                        wr_entry.uav_pending  = (state_reg == uav_mask_reg) &&
                                                (rd_entry.last_mask == state_reg);
                    end
                end
                ACT_FLUSH:
                begin
                    wr_en                = 1'b1;
                    wr_entry.last_mask   = rd_entry.current_mask;
                    wr_entry.uav_pending = 1'b0;
                    if (rd_entry.uav_pending)
                    begin
                        res_new  = 1'b1;
                        res_kind = KIND_UAV;
                    end
                    else if (rd_entry.current_mask != rd_entry.last_mask)
                    begin
                        res_new    = 1'b1;
                        res_kind   = KIND_TRANS;
                        res_before = rd_entry.last_mask;
                        res_after  = rd_entry.current_mask;
                    end
                end
                ACT_RESTORE:
                begin
                    if (rd_entry.initial_mask != rd_entry.last_mask)
                    begin
                        res_new    = 1'b1;
                        res_kind   = KIND_TRANS;
                        res_before = rd_entry.last_mask;
                        res_after  = rd_entry.initial_mask;
                    end
                end
                default:
                begin
                    res_new = 1'b0;
                end
            endcase
        end
        else if (cmd.insert && !table_full)
        begin
            wr_en                 = 1'b1;
            wr_addr               = count_reg[IDX_W-1:0];
            wr_entry.key          = key_reg;
            wr_entry.initial_mask = init_reg;
            wr_entry.last_mask    = init_reg;
            wr_entry.current_mask = state_reg;
            wr_entry.uav_pending  = 1'b0;
        end
    end

    // Control registers: config, fill count, scan index, pending flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            uav_mask_reg     <= UAV_MASK_RESET;
            count_reg        <= '0;
            idx_reg          <= '0;
            status_reg       <= STATUS_OK;
            pend_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= 1'b0;
            if (cfg_we)
            begin
                uav_mask_reg <= cfg_data;
            end
            if (cmd.load)
            begin
                idx_reg        <= '0;
                status_reg     <= STATUS_OK;
                pend_valid_reg <= 1'b0;
            end
            if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
            if (res_new)
            begin
                pend_valid_reg <= 1'b1;
                if (pend_valid_reg)
                begin
                    result_valid_reg <= 1'b1;
                end
            end
            if (cmd.insert)
            begin
                if (table_full)
                begin
                    status_reg <= STATUS_FULL;
                end
                else
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
            end
            if (cmd.finish)
            begin
                result_valid_reg <= 1'b1;
                pend_valid_reg   <= 1'b0;
                if (cmd.op == ACT_RESTORE)
                begin
                    count_reg <= '0;
                end
            end
        end
    end

    // Payload registers: latched item, held result and output result.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg   <= resource_key;
            state_reg <= new_state;
            init_reg  <= initial_state;
        end
        if (res_new)
        begin
            // A newer result pushes the held one out; it is not the final one.
            out_kind_reg    <= pend_kind_reg;
            out_key_reg     <= pend_key_reg;
            out_before_reg  <= pend_before_reg;
            out_after_reg   <= pend_after_reg;
            out_status_reg  <= STATUS_OK;
            out_last_reg    <= 1'b0;
            pend_kind_reg   <= res_kind;
            pend_key_reg    <= rd_entry.key;
            pend_before_reg <= res_before;
            pend_after_reg  <= res_after;
        end
        if (cmd.finish)
        begin
            out_last_reg <= 1'b1;
            if (pend_valid_reg)
            begin
                out_kind_reg   <= pend_kind_reg;
                out_key_reg    <= pend_key_reg;
                out_before_reg <= pend_before_reg;
                out_after_reg  <= pend_after_reg;
                out_status_reg <= STATUS_OK;
            end
            else
            begin
                out_kind_reg   <= KIND_NONE;
                out_key_reg    <= '0;
                out_before_reg <= '0;
                out_after_reg  <= '0;
                out_status_reg <= status_reg;
            end
        end
    end

    assign result_valid     = result_valid_reg;
    assign barrier_kind     = out_kind_reg;
    assign barrier_resource = out_key_reg;
    assign state_before     = out_before_reg;
    assign state_after      = out_after_reg;
    assign status           = out_status_reg;
    assign last_result      = out_last_reg;

endmodule

// File: hw/rtl/resource_barrier_tracker_unit.sv
// Top level of the resource barrier tracker: controller, datapath and checks.
//
// An item is taken when start is high and busy is low; busy then stays high until
// the item's last result has been issued. Entries live in one RAM and are visited
// one at a time (read, then evaluate and write back), so the entry RAM's single
// read port sets the rate. Results leave through an output register, one per
// strobe on result_valid, and are held for that single cycle only: the receiver
// cannot stall them. The final result of each item carries last_result. The
// configuration register is written through cfg_valid/cfg_ready, and the transfer
// is taken only while the block is not busy.
`include "resource_barrier_tracker_unit_macros.svh"

module resource_barrier_tracker_unit
    import rbt_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  action,
    input  logic [31:0] resource_key,
    input  logic [31:0] new_state,
    input  logic [31:0] initial_state,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    output logic        result_valid,
    output logic [1:0]  barrier_kind,
    output logic [31:0] barrier_resource,
    output logic [31:0] state_before,
    output logic [31:0] state_after,
    output logic        status,
    output logic        last_result
);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    assign cfg_ready = !busy;

    rbt_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .stat   (stat),
        .cmd    (cmd),
        .busy   (busy)
    );

    rbt_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_valid && cfg_ready),
        .cfg_data         (cfg_data),
        .cmd              (cmd),
        .stat             (stat),
        .resource_key     (resource_key),
        .new_state        (new_state),
        .initial_state    (initial_state),
        .result_valid     (result_valid),
        .barrier_kind     (barrier_kind),
        .barrier_resource (barrier_resource),
        .state_before     (state_before),
        .state_after      (state_after),
        .status           (status),
        .last_result      (last_result)
    );

    // An accepted item always occupies the block in the following cycle.
    `RBT_ASSERT(a_accept_then_busy, clk, rst_n, start && !busy |=> busy)
    // The final result of an item appears exactly as the block goes idle.
    `RBT_ASSERT(a_last_when_idle, clk, rst_n, result_valid && last_result |-> !busy)
    // Earlier results of an item appear while it is still being worked on.
    `RBT_ASSERT(a_mid_while_busy, clk, rst_n, result_valid && !last_result |-> busy)
    // A dropped record reports through a single final 'none' result.
    `RBT_ASSERT_NEVER(a_full_only_none, clk, rst_n,
                      result_valid && status && (barrier_kind != KIND_NONE || !last_result))

endmodule

// File: dv/rbt_barrier_checker.sv
// Checker for the resource barrier tracker: predicts barriers and checks each result transfer.
`timescale 1ns / 100ps

module rbt_barrier_checker
    import rbt_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  action,
    input  logic [31:0] resource_key,
    input  logic [31:0] new_state,
    input  logic [31:0] initial_state,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [31:0] cfg_data,
    input  logic        result_valid,
    input  logic [1:0]  barrier_kind,
    input  logic [31:0] barrier_resource,
    input  logic [31:0] state_before,
    input  logic [31:0] state_after,
    input  logic        status,
    input  logic        last_result,
    output int          mismatches,
    output int          outstanding,
    output int          results_seen,
    output int          uav_seen,
    output int          trans_seen,
    output int          full_seen
);

    // One expected result transfer.
    typedef struct packed {
        kind_t       kind;
        logic [31:0] resource;
        logic [31:0] before_mask;
        logic [31:0] after_mask;
        logic        status;
        logic        last;
    } barrier_t;

    // Shadow copy of the resource table and the unordered-access mask.
    entry_t      slots [TABLE_ENTRIES];
    int          slot_count = 0;
    logic [31:0] uav_mask = UAV_MASK_RESET;

    barrier_t    pending_barriers [$];
    barrier_t    head;
    int          err_count = 0;
    int          n_results = 0;
    int          n_uav = 0;
    int          n_trans = 0;
    int          n_full = 0;

    // Work out the barriers that one accepted command produces and queue them.
    function automatic void predict_barriers(input action_t op, input logic [31:0] key,
                                             input logic [31:0] next_mask,
                                             input logic [31:0] init_mask);
        barrier_t batch [$];
        barrier_t b;
        int       hit;
        logic     dropped;
        hit = -1;
        dropped = STATUS_OK;
        case (op)
            ACT_RECORD:
            begin
                // Slots fill from zero upward, so the live entries are contiguous.
                for (int i = 0; i < slot_count; i++)
                    if (hit < 0 && slots[i].key == key)
                        hit = i;
                if (hit >= 0)
                begin
                    slots[hit].uav_pending = (next_mask == uav_mask) &&
                                             (slots[hit].last_mask == next_mask);
                    slots[hit].current_mask = next_mask;
                end
                else if (slot_count >= TABLE_ENTRIES)
                    dropped = STATUS_FULL;
                else
                begin
                    slots[slot_count] = '{key: key, initial_mask: init_mask,
                                          last_mask: init_mask, current_mask: next_mask,
                                          uav_pending: 1'b0};
                    slot_count++;
                end
            end
            ACT_FLUSH:
            begin
                // A pending UAV wins over a transition; every entry is committed.
                for (int i = 0; i < slot_count; i++)
                begin
                    b = '0;
                    b.resource = slots[i].key;
                    if (slots[i].uav_pending)
                    begin
                        b.kind = KIND_UAV;
                        batch.push_back(b);
                        slots[i].uav_pending = 1'b0;
                    end
                    else if (slots[i].current_mask != slots[i].last_mask)
                    begin
                        b.kind = KIND_TRANS;
                        b.before_mask = slots[i].last_mask;
                        b.after_mask = slots[i].current_mask;
                        batch.push_back(b);
                    end
                    slots[i].last_mask = slots[i].current_mask;
                end
            end
            ACT_RESTORE:
            begin
                // Transition each entry back to its initial mask, then empty the table.
                for (int i = 0; i < slot_count; i++)
                begin
                    if (slots[i].initial_mask != slots[i].last_mask)
                    begin
                        b = '0;
                        b.kind = KIND_TRANS;
                        b.resource = slots[i].key;
                        b.before_mask = slots[i].last_mask;
                        b.after_mask = slots[i].initial_mask;
                        batch.push_back(b);
                    end
                end
                slot_count = 0;
            end
            default:
            begin
            end
        endcase

        // A command without barriers still returns a single 'none' result.
        if (batch.size() == 0)
        begin
            b = '0;
            b.kind = KIND_NONE;
            b.status = dropped;
            batch.push_back(b);
        end
        b = batch.pop_back();
        b.last = 1'b1;
        batch.push_back(b);
        foreach (batch[i])
            pending_barriers.push_back(batch[i]);
    endfunction

    // Report one field that differs from its expected value.
    function automatic void compare_field(input string name, input logic [31:0] expected,
                                          input logic [31:0] actual);
        if (actual !== expected)
        begin
            $display("%0t: mismatch on %s: expected 0x%08h, actual 0x%08h",
                     $time, name, expected, actual);
            err_count++;
        end
    endfunction

    // Watch the three channels at each rising edge.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            slot_count = 0;
            uav_mask = UAV_MASK_RESET;
            pending_barriers.delete();
        end
        else
        begin
            // A result transfer is compared with the oldest expected barrier.
            if (result_valid)
            begin
                if (pending_barriers.size() == 0)
                begin
                    $display("%0t: expected no result, actual kind %0d, key 0x%08h",
                             $time, barrier_kind, barrier_resource);
                    err_count++;
                end
                else
                begin
                    head = pending_barriers.pop_front();
                    compare_field("barrier_kind", 32'(head.kind), 32'(barrier_kind));
                    compare_field("barrier_resource", head.resource, barrier_resource);
                    compare_field("state_before", head.before_mask, state_before);
                    compare_field("state_after", head.after_mask, state_after);
                    compare_field("status", 32'(head.status), 32'(status));
                    compare_field("last_result", 32'(head.last), 32'(last_result));
                    n_results++;
                    if (head.kind == KIND_UAV)
                        n_uav++;
                    if (head.kind == KIND_TRANS)
                        n_trans++;
                    if (head.status == STATUS_FULL)
                        n_full++;
                end
            end

            // Configuration transfer.
            if (cfg_valid && cfg_ready)
                uav_mask = cfg_data;

            // Command transfer.
            if (start && !busy)
                predict_barriers(action_t'(action), resource_key, new_state, initial_state);
        end

        mismatches <= err_count;
        outstanding <= pending_barriers.size();
        results_seen <= n_results;
        uav_seen <= n_uav;
        trans_seen <= n_trans;
        full_seen <= n_full;
    end

endmodule

// File: dv/resource_barrier_tracker_unit_test.sv
// Testbench top for the resource barrier tracker: commands, configuration and the verdict.
`timescale 1ns / 100ps

module resource_barrier_tracker_unit_test;
    import rbt_pkg::*;

    localparam int      TABLE_ENTRIES = 16;
    localparam int      QUIET_LIMIT = 500;
    localparam int      TAIL_CYCLES = 40;
    localparam int      KEY_POOL = 24;
    localparam int      PHASE_ITEMS = 51;
    localparam action_t ACT_UNUSED = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  action;
    logic [31:0] resource_key;
    logic [31:0] new_state;
    logic [31:0] initial_state;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;
    logic        result_valid;
    logic [1:0]  barrier_kind;
    logic [31:0] barrier_resource;
    logic [31:0] state_before;
    logic [31:0] state_after;
    logic        status;
    logic        last_result;

    int          mismatches;
    int          outstanding;
    int          results_seen;
    int          uav_seen;
    int          trans_seen;
    int          full_seen;

    int          idle_pct;
    int          cmd_count [4];
    int          mask_writes;
    int          quiet_cycles = 0;
    logic [31:0] uav_mask_now;
    logic [31:0] key_pool [KEY_POOL];

    resource_barrier_tracker_unit #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .action(action),
        .resource_key(resource_key),
        .new_state(new_state),
        .initial_state(initial_state),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .result_valid(result_valid),
        .barrier_kind(barrier_kind),
        .barrier_resource(barrier_resource),
        .state_before(state_before),
        .state_after(state_after),
        .status(status),
        .last_result(last_result)
    );

    rbt_barrier_checker #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .action(action),
        .resource_key(resource_key),
        .new_state(new_state),
        .initial_state(initial_state),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .result_valid(result_valid),
        .barrier_kind(barrier_kind),
        .barrier_resource(barrier_resource),
        .state_before(state_before),
        .state_after(state_after),
        .status(status),
        .last_result(last_result),
        .mismatches(mismatches),
        .outstanding(outstanding),
        .results_seen(results_seen),
        .uav_seen(uav_seen),
        .trans_seen(trans_seen),
        .full_seen(full_seen)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: end the run when no transfer of any kind happens for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: watchdog expired after %0d cycles without a transfer",
                     $time, quiet_cycles);
            $display("RESULT: ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Offer one command and hold it until the block takes it.
    task automatic send_command(input action_t op, input logic [31:0] key,
                                input logic [31:0] next_mask, input logic [31:0] init_mask);
        // The sender idles in each cycle with a chance of idle_pct percent, so start
        // can rise at any point of the previous command's work.
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        action <= op;
        resource_key <= key;
        new_state <= next_mask;
        initial_state <= init_mask;
        do
            @(posedge clk);
        while (busy);
        cmd_count[op]++;
    endtask

    // Hold off new commands until every expected result has been transferred.
    task automatic drain_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0 || busy);
    endtask

    // Write the unordered-access mask while the block is idle.
    task automatic write_uav_mask(input logic [31:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        uav_mask_now = value;
        mask_writes++;
    endtask

    // State masks lean toward the UAV mask so that repeats and barriers happen often.
    function automatic logic [31:0] pick_mask();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return uav_mask_now;
        if (r < 60)
            return 32'd1 << $urandom_range(0, 31);
        if (r < 72)
            return 32'd0;
        if (r < 82)
            return '1;
        return $urandom;
    endfunction

    // Mostly records on a key pool a little larger than the table, with flushes
    // between them, rare restores and a few commands with the unused code.
    task automatic random_command();
        int          r;
        logic [31:0] key;
        r = $urandom_range(0, 99);
        if (r < 3)
            send_command(ACT_UNUSED, $urandom, $urandom, $urandom);
        else if (r < 6)
            send_command(ACT_RESTORE, $urandom, $urandom, $urandom);
        else if (r < 20)
            send_command(ACT_FLUSH, $urandom, $urandom, $urandom);
        else
        begin
            if ($urandom_range(0, 9) == 0)
                key = $urandom;
            else
                key = key_pool[$urandom_range(0, KEY_POOL - 1)];
            send_command(ACT_RECORD, key, pick_mask(), pick_mask());
        end
        if ($urandom_range(0, 99) == 0)
            drain_results();
    endtask

    // Stimulus and verdict.
    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        action = ACT_RECORD;
        resource_key = '0;
        new_state = '0;
        initial_state = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        idle_pct = 0;
        mask_writes = 0;
        uav_mask_now = UAV_MASK_RESET;
        foreach (cmd_count[i])
            cmd_count[i] = 0;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < KEY_POOL; i++)
            key_pool[i] = $urandom;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, with the mask at its reset value.
        send_command(ACT_FLUSH, '1, '1, '1);
        send_command(ACT_RESTORE, '1, '1, '1);
        send_command(ACT_UNUSED, '1, '1, '1);
        send_command(ACT_RECORD, '0, UAV_MASK_RESET, '0);
        send_command(ACT_RECORD, '1, '1, '1);
        send_command(ACT_FLUSH, '0, '0, '0);
        // Repeating the UAV state on a committed entry raises a UAV barrier.
        send_command(ACT_RECORD, '0, UAV_MASK_RESET, '1);
        // Known key: the stored initial mask must be kept.
        send_command(ACT_RECORD, '1, '0, '0);
        send_command(ACT_FLUSH, '0, '0, '0);
        // Nothing changed since the last flush.
        send_command(ACT_FLUSH, '0, '0, '0);
        // Fill the table; the last new key is dropped.
        for (int i = 2; i <= TABLE_ENTRIES; i++)
            send_command(ACT_RECORD, key_pool[i], pick_mask(), pick_mask());
        send_command(ACT_FLUSH, '0, '0, '0);
        send_command(ACT_RESTORE, '0, '0, '0);

        // Random phases, each under its own mask and idling pattern.
        write_uav_mask('0);
        idle_pct = 10;
        repeat (PHASE_ITEMS) random_command();

        write_uav_mask('1);
        idle_pct = 65;
        repeat (PHASE_ITEMS) random_command();

        write_uav_mask($urandom);
        idle_pct = 0;
        repeat (PHASE_ITEMS) random_command();

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d commands (%0d record, %0d flush, %0d restore, %0d unused)",
                 cmd_count[0] + cmd_count[1] + cmd_count[2] + cmd_count[3],
                 cmd_count[ACT_RECORD], cmd_count[ACT_FLUSH], cmd_count[ACT_RESTORE],
                 cmd_count[ACT_UNUSED]);
        $display("under %0d mask settings, checking %0d result transfers: %0d UAV barriers,",
                 mask_writes + 1, results_seen, uav_seen);
        $display("%0d transitions and %0d table-full drops.", trans_seen, full_seen);
        if (mismatches == 0 && outstanding == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
